@@ hdl/spq_pkg.sv @@
// Package with shared constants, codes and types of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W = 16;
	localparam int RANK_W = 4;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;

	localparam int IN_BITS = MODE_W + ID_W + RANK_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ID_W + RANK_W + STATUS_W + OCC_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_REM = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// One held entry.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RANK_W-1:0] rank;
	} entry_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic              do_ins;
		logic              do_del;
		logic              del_head;
		logic [ID_W-1:0]   id;
		logic [RANK_W-1:0] rank;
	} cell_cmd_t;

endpackage

@@ hdl/spq_cell.sv @@
// One cell of the sorted row: holds a single entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  spq_pkg::entry_t    left,
	input  logic               ins_left,
	input  spq_pkg::entry_t    right,
	input  logic               hit_in,
	output spq_pkg::entry_t    entry,
	output logic               ins,
	output logic               hit_out
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;
	spq_pkg::entry_t fresh;
	logic            match;
	logic            wr_en;

	// A cell lies at or after the insert point when it is empty or holds a higher rank.
	assign ins = !occ || (entry_q.rank > cmd.rank);

	assign match = occ && !cmd.del_head && (entry_q.id == cmd.id);
	assign hit_out = hit_in || match;

	assign fresh.id = cmd.id;
	assign fresh.rank = cmd.rank;

	always_comb begin
		wr_en = 1'b0;
		entry_d = entry_q;
		if (cmd.do_ins && ins) begin
			wr_en = 1'b1;
			entry_d = ins_left ? left : fresh;
		end else if (cmd.do_del && hit_out) begin
			wr_en = 1'b1;
			entry_d = right;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

@@ hdl/stable_priority_queue.sv @@
// Top level of the stable priority queue: a row of entry cells, the fill count and the result register.
//
//   channel | dir | tdata fields (lowest bit up)
//   s_axis  | in  | mode[1:0], item_id[17:2], rank[21:18], zero pad to 24 bits
//   m_axis  | out | out_id[15:0], out_rank[19:16], status[21:20], occupancy[26:22], pad to 32
//
// All cells compare against the broadcast item at once and shift in the same edge, so the longest
// path is the match flag rippling down the row.
// Reset clears the fill count and the result valid flag; cell contents stay as they are.
// The result register takes a new item whenever it is empty or is being read in that
// cycle, so a stalled output holds back the input only while the result waits.
`timescale 1ns / 1ps

module stable_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spq_pkg::IN_TDATA_W-1:0]     s_tdata,  // mode, item_id, rank
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata   // out_id, out_rank, status, occupancy
);

	localparam int D = spq_pkg::DEPTH;

	spq_pkg::mode_t            mode;
	logic [spq_pkg::ID_W-1:0]   item_id;
	logic [spq_pkg::RANK_W-1:0] rank;
	logic                       accept;

	logic [spq_pkg::CNT_W-1:0]  cnt_q;
	logic [spq_pkg::CNT_W-1:0]  cnt_d;
	logic                       full;
	logic                       empty;
	logic                       found;

	spq_pkg::cell_cmd_t         cmd;
	spq_pkg::entry_t            cell_q [D];
	logic                       ins [D];
	logic                       hit [D+1];

	spq_pkg::status_t           status_d;
	spq_pkg::status_t           status_q;
	logic [spq_pkg::ID_W-1:0]   out_id_q;
	logic [spq_pkg::RANK_W-1:0] out_rank_q;
	logic [spq_pkg::OCC_W-1:0]  occ_q;
	logic [spq_pkg::OCC_W+spq_pkg::CNT_W-1:0] occ_wide;

	assign mode = spq_pkg::mode_t'(s_tdata[spq_pkg::MODE_W-1:0]);
	assign item_id = s_tdata[spq_pkg::MODE_W +: spq_pkg::ID_W];
	assign rank = s_tdata[spq_pkg::MODE_W + spq_pkg::ID_W +: spq_pkg::RANK_W];

	assign s_tready = !m_tvalid || m_tready;
	assign accept = s_tvalid && s_tready;

	assign full = (cnt_q == spq_pkg::CNT_W'(D));
	assign empty = (cnt_q == '0);

	always_comb begin
		cmd.id = item_id;
		cmd.rank = rank;
		cmd.do_ins = accept && (mode == spq_pkg::MODE_ENQ) && !full;
		cmd.del_head = (mode == spq_pkg::MODE_DEQ);
		cmd.do_del = accept && ((mode == spq_pkg::MODE_DEQ) || (mode == spq_pkg::MODE_REM));
	end

	// The head seeds the shift chain on a dequeue; a remove seeds it at the first match.
	assign hit[0] = cmd.del_head && !empty;

	for (genvar k = 0; k < D; k++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            ins_left;
		logic            occ;

		assign occ = (spq_pkg::CNT_W'(k) < cnt_q);

		if (k == 0) begin : g_first
			assign left_e = '0;
			assign ins_left = 1'b0;
		end else begin : g_mid
			assign left_e = cell_q[k-1];
			assign ins_left = ins[k-1];
		end

		if (k == D - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_q[k+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.occ      (occ),
			.left     (left_e),
			.ins_left (ins_left),
			.right    (right_e),
			.hit_in   (hit[k]),
			.entry    (cell_q[k]),
			.ins      (ins[k]),
			.hit_out  (hit[k+1])
		);
	end

	assign found = hit[D];

	always_comb begin
		cnt_d = cnt_q;
		status_d = spq_pkg::ST_OK;
		case (mode)
			spq_pkg::MODE_ENQ: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			spq_pkg::MODE_DEQ: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			spq_pkg::MODE_REM: begin
				if (found) begin
					cnt_d = cnt_q - 1'b1;
				end else begin
					status_d = spq_pkg::ST_MISSING;
				end
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, cnt_d};

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			occ_q <= occ_wide[spq_pkg::OCC_W-1:0];
			if (cmd.del_head && !empty) begin
				out_id_q <= cell_q[0].id;
				out_rank_q <= cell_q[0].rank;
			end else begin
				out_id_q <= '0;
				out_rank_q <= '0;
			end
		end
	end

	assign m_tdata = {{(spq_pkg::OUT_TDATA_W - spq_pkg::OUT_BITS){1'b0}},
		occ_q, status_q, out_rank_q, out_id_q};

	logic unused_pad;
	assign unused_pad = ^s_tdata[spq_pkg::IN_TDATA_W-1:spq_pkg::IN_BITS];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spq_pkg::CNT_W'(D))
		else $error("fill count above depth");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_deq_pops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == spq_pkg::MODE_DEQ) && !empty |=>
		(status_q == spq_pkg::ST_OK) && (cnt_q == $past(cnt_q) - 1'b1))
		else $error("dequeue of a held entry did not pop");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == spq_pkg::MODE_REM) && !found |=> $stable(cnt_q))
		else $error("unmatched remove changed the fill count");

	a_full_refuses: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == spq_pkg::MODE_ENQ) && full |=>
		(status_q == spq_pkg::ST_FULL) && $stable(cnt_q))
		else $error("enqueue into a full store was not refused");

endmodule

@@ test/stable_priority_queue_tb.sv @@
// Self-checking testbench for the stable priority queue with randomized stream traffic.
`timescale 1ns / 1ps

module stable_priority_queue_tb;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [RANK_W-1:0] rank;
		status_t           status;
		logic [OCC_W-1:0]  occ;
	} reply_t;

	// Tracks the queue contents and checks every result against the oldest prediction.
	class spq_scoreboard;
		entry_t held[DEPTH];
		int unsigned fill;
		reply_t awaited[$];
		int unsigned errors;
		int unsigned replies;
		int unsigned refused_full;
		int unsigned empty_pops;
		int unsigned missing_ids;
		int unsigned removed;
		int unsigned pops;
		int unsigned idle_ops;
		int unsigned times_full;

		function new();
			fill = 0;
			errors = 0;
			replies = 0;
			refused_full = 0;
			empty_pops = 0;
			missing_ids = 0;
			removed = 0;
			pops = 0;
			idle_ops = 0;
			times_full = 0;
		endfunction

		// Removes the entry at pos; later entries move one place toward the head.
		function void close_gap(int unsigned pos);
			for (int unsigned k = pos; k + 1 < fill; k++)
				held[k] = held[k + 1];
			fill--;
		endfunction

		function void note_request(mode_t m, logic [ID_W-1:0] id, logic [RANK_W-1:0] rk);
			reply_t r;
			int unsigned pos;
			bit found;
			r.id = '0;
			r.rank = '0;
			r.status = ST_OK;
			found = 1'b0;
			case (m)
			MODE_ENQ: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
					refused_full++;
				end else begin
					// The new entry goes behind every entry of equal or lower rank.
					pos = 0;
					while (pos < fill && held[pos].rank <= rk)
						pos++;
					for (int unsigned k = fill; k > pos; k--)
						held[k] = held[k - 1];
					held[pos].id = id;
					held[pos].rank = rk;
					fill++;
					if (fill == DEPTH)
						times_full++;
				end
			end
			MODE_DEQ: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
					empty_pops++;
				end else begin
					r.id = held[0].id;
					r.rank = held[0].rank;
					close_gap(0);
					pops++;
				end
			end
			MODE_REM: begin
				for (int unsigned k = 0; k < fill && !found; k++) begin
					if (held[k].id == id) begin
						close_gap(k);
						found = 1'b1;
					end
				end
				if (found)
					removed++;
				else begin
					r.status = ST_MISSING;
					missing_ids++;
				end
			end
			default: begin
				idle_ops++;
			end
			endcase
			r.occ = OCC_W'(fill);
			awaited.push_back(r);
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: mismatch: %s", $time, what);
		endfunction

		function string show(reply_t r);
			return $sformatf("id %h rank %h status %s occupancy %0d",
				r.id, r.rank, r.status.name(), r.occ);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] word);
			reply_t want;
			reply_t got;
			logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
			got.id = word[ID_W-1:0];
			got.rank = word[ID_W +: RANK_W];
			got.status = status_t'(word[ID_W+RANK_W +: STATUS_W]);
			got.occ = word[ID_W+RANK_W+STATUS_W +: OCC_W];
			pad = word[OUT_TDATA_W-1:OUT_BITS];
			replies++;
			if (awaited.size() == 0) begin
				flag({"result with nothing expected: ", show(got)});
				return;
			end
			want = awaited.pop_front();
			if (got.id !== want.id || got.rank !== want.rank || got.status !== want.status
					|| got.occ !== want.occ || pad !== '0)
				flag($sformatf("result %0d expected %s, got %s pad %h",
					replies, show(want), show(got), pad));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	spq_scoreboard sb = new();
	bit send_eager = 1'b0;
	int unsigned sent = 0;
	int unsigned stalled_cycles = 0;

	always #5 clk = ~clk;

	stable_priority_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Valid is lowered only when a gap follows, so it never gets two updates in one step.
	task automatic send_request(input mode_t m, input logic [ID_W-1:0] id,
			input logic [RANK_W-1:0] rk);
		int unsigned gap;
		gap = send_eager ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, rk, id, m};
		do @(posedge clk); while (!s_tready);
		sb.note_request(m, id, rk);
		sent++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() > 0)
			@(posedge clk);
	endtask

	task automatic directed_requests();
		logic [ID_W-1:0] ids [16] = '{16'h0000, 16'hFFFF, 16'h0003, 16'h8000, 16'h0003,
			16'h0001, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h5A5A, 16'hA5A5, 16'h0F0F,
			16'hF0F0, 16'h1111, 16'h0003, 16'hFFFE};
		logic [RANK_W-1:0] ranks [16] = '{4'd15, 4'd5, 4'd5, 4'd0, 4'd5, 4'd15, 4'd0,
			4'd3, 4'd3, 4'd3, 4'd7, 4'd15, 4'd0, 4'd9, 4'd5, 4'd1};
		send_request(MODE_DEQ, 16'h0000, 4'd0);
		send_request(MODE_REM, 16'hFFFF, 4'd15);
		send_request(MODE_NOP, 16'hFFFF, 4'd15);
		for (int k = 0; k < 16; k++)
			send_request(MODE_ENQ, ids[k], ranks[k]);
		send_request(MODE_ENQ, 16'hAAAA, 4'd0);
		// Id 3 is held three times; only the copy nearest the head goes.
		send_request(MODE_REM, 16'h0003, 4'd0);
		send_request(MODE_REM, 16'h1234, 4'd5);
		send_request(MODE_DEQ, 16'h0000, 4'd0);
		send_request(MODE_DEQ, 16'hFFFF, 4'd15);
		send_request(MODE_NOP, 16'h5555, 4'd10);
	endtask

	// The bias steers phases toward filling, draining, or a mix of both.
	task automatic random_request(input int unsigned bias);
		int unsigned roll;
		int unsigned enq_cut;
		int unsigned deq_cut;
		mode_t m;
		logic [ID_W-1:0] id;
		logic [RANK_W-1:0] rk;
		case (bias)
		0: begin
			enq_cut = 75;
			deq_cut = 88;
		end
		1: begin
			enq_cut = 30;
			deq_cut = 80;
		end
		default: begin
			enq_cut = 50;
			deq_cut = 78;
		end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 3)
			m = MODE_NOP;
		else if (roll < enq_cut)
			m = MODE_ENQ;
		else if (roll < deq_cut)
			m = MODE_DEQ;
		else
			m = MODE_REM;
		// Narrow ranks give many ties; a small id pool gives duplicate ids.
		rk = ($urandom_range(0, 1) == 1) ? RANK_W'($urandom_range(0, 15))
			: RANK_W'($urandom_range(0, 3));
		id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 31));
		if (m == MODE_REM && sb.fill > 0 && $urandom_range(0, 3) != 0)
			id = sb.held[$urandom_range(0, sb.fill - 1)].id;
		send_request(m, id, rk);
	endtask

	initial begin
		int unsigned gap;
		int unsigned left;
		bit eager;
		left = 0;
		eager = 1'b0;
		forever begin
			if (left == 0) begin
				eager = ($urandom_range(0, 3) == 0);
				left = $urandom_range(10, 60);
			end
			left--;
			gap = eager ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("stable_priority_queue_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned bias;
		bias = 2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		directed_requests();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				bias = $urandom_range(0, 2);
				send_eager = ($urandom_range(0, 3) == 0);
			end
			if (n == 600 || n == 1200)
				hold_until_drained();
			random_request(bias);
		end
		s_tvalid <= 1'b0;
		while (sb.awaited.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d items, %0d results: %0d pops, %0d removes, %0d idle ops.",
			sent, sb.replies, sb.pops, sb.removed, sb.idle_ops);
		$display("Queue filled %0d times; %0d refused as full, %0d empty pops, %0d ids missing.",
			sb.times_full, sb.refused_full, sb.empty_pops, sb.missing_ids);
		if (sb.errors == 0)
			$display("stable_priority_queue_tb: PASS");
		else begin
			$display("%0d mismatches in total", sb.errors);
			$display("stable_priority_queue_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
test/stable_priority_queue_tb.sv
